### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the trace decay engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define STDP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define STDP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define STDP_ASSERT(lbl, clk, rst, prop)

`define STDP_ASSERT_NR(lbl, clk, prop)

`endif

`endif

### src/stdp_pkg.sv
// ----------------------------------------------------------------------------
// stdp_pkg
// Types, constants and the exponential table builder of the trace engine.
// ----------------------------------------------------------------------------
package stdp_pkg;

  localparam int SYNAPSES          = 1024;
  localparam int EXP_TABLE_ENTRIES = 1024;

  localparam int SYN_AW   = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int ROM_AW   = $clog2(EXP_TABLE_ENTRIES);
  localparam int ROM_SHIFT = 10;

  localparam int TRACE_W  = 24;
  localparam int FACTOR_W = 17;
  localparam int TIME_W   = 32;
  localparam int TAU_W    = 16;
  localparam int ARG_W    = TIME_W + TAU_W;
  localparam int PROD_W   = TRACE_W + FACTOR_W;

  localparam logic [TAU_W-1:0]   INV_TAU_RESET = 16'd656;
  localparam logic [TRACE_W:0]   ONE_Q16       = 25'd65536;
  localparam logic [TRACE_W-1:0] TRACE_MAX     = 24'hFFFFFF;
  localparam logic [PROD_W-1:0]  ROUND_HALF    = 41'h8000;
  localparam logic [63:0]        EXP_STEP_Q32  = 64'd4228380000;

  typedef enum logic [1:0] {
    MODE_DECAY = 2'd0,
    MODE_PRE   = 2'd1,
    MODE_POST  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last;
    logic [TRACE_W-1:0] post;
    logic [TRACE_W-1:0] pre;
  } trace_word_t;

  typedef logic [FACTOR_W-1:0] exp_rom_t [EXP_TABLE_ENTRIES];

  // Entry k holds exp(-k/64) in Q1.16, from a Q32.32 accumulator stepped by
  // a rounded multiplication per entry.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t   rom;
    logic [63:0] acc;
    logic [63:0] sum;
    acc = 64'd1 << 32;
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      sum = acc + 64'h8000;
      rom[k] = sum[16 +: FACTOR_W];
      acc = (acc * EXP_STEP_Q32 + 64'h80000000) >> 32;
    end
    return rom;
  endfunction

endpackage

### src/stdp_exp_rom.sv
// ----------------------------------------------------------------------------
// stdp_exp_rom
// Exponential decay factor table with a registered read.
// ----------------------------------------------------------------------------
module stdp_exp_rom (
  input  logic                                clk,
  input  logic [stdp_pkg::ROM_AW-1:0]         addr,
  output logic [stdp_pkg::FACTOR_W-1:0]       factor
);

  localparam stdp_pkg::exp_rom_t ROM = stdp_pkg::build_exp_rom();

  always_ff @(posedge clk) begin
    factor <= ROM[addr];
  end

endmodule

### src/stdp_trace_decay_engine.sv
// ----------------------------------------------------------------------------
// stdp_trace_decay_engine
// Per-synapse STDP activity traces with exponential decay and spike bumps.
// ----------------------------------------------------------------------------
// Each request passes through ST_READ, ST_LOOKUP and ST_SCALE on its way
// from acceptance to the output register. The trace memory is read at
// acceptance. These states then do the elapsed time times inv_tau multiply,
// the decay table read, and the trace scaling with write-back. One request is
// in flight at a time, so a new request is taken only once the block is back
// in ST_IDLE. A request may be taken while the previous result still waits
// on out_stall. It then holds in its last stage, with in_stall high, until
// that result leaves. After reset the block clears its whole trace memory
// with in_stall high. Configuration writes are taken throughout.
module stdp_trace_decay_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [stdp_pkg::TAU_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [9:0]                        synapse,
  input  logic [stdp_pkg::TIME_W-1:0]       time_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stdp_pkg::TRACE_W-1:0]      pre_trace,
  output logic [stdp_pkg::TRACE_W-1:0]      post_trace
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_LOOKUP = 5'b01000,
    ST_SCALE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [stdp_pkg::TAU_W-1:0]    inv_tau;
  logic [stdp_pkg::SYN_AW-1:0]   clr_cnt;

  logic [1:0]                    mode_q;
  logic [stdp_pkg::SYN_AW-1:0]   addr_q;
  logic                          syn_ok_q;
  logic [stdp_pkg::TIME_W-1:0]   time_q;

  stdp_pkg::trace_word_t         mem [stdp_pkg::SYNAPSES];
  stdp_pkg::trace_word_t         mem_q;
  logic                          mem_we;
  logic [stdp_pkg::SYN_AW-1:0]   mem_waddr;
  stdp_pkg::trace_word_t         mem_wdata;

  logic                          accept;
  logic                          advance;
  logic [stdp_pkg::TIME_W-1:0]   elapsed;
  logic [stdp_pkg::ARG_W-1:0]    arg_q;
  logic                          rom_hit_q;
  logic [stdp_pkg::FACTOR_W-1:0] rom_data;
  logic [stdp_pkg::FACTOR_W-1:0] factor;
  logic [stdp_pkg::PROD_W-1:0]   pre_prod;
  logic [stdp_pkg::PROD_W-1:0]   post_prod;
  logic [stdp_pkg::TRACE_W-1:0]  pre_dec;
  logic [stdp_pkg::TRACE_W-1:0]  post_dec;
  logic [stdp_pkg::TRACE_W:0]    pre_sum;
  logic [stdp_pkg::TRACE_W:0]    post_sum;
  logic [stdp_pkg::TRACE_W-1:0]  pre_bump;
  logic [stdp_pkg::TRACE_W-1:0]  post_bump;
  stdp_pkg::trace_word_t         word_next;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign advance  = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_tau <= stdp_pkg::INV_TAU_RESET;
    end else if (cfg_we) begin
      inv_tau <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == stdp_pkg::SYN_AW'(stdp_pkg::SYNAPSES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_SCALE;
      ST_SCALE: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      addr_q   <= stdp_pkg::SYN_AW'(synapse);
      syn_ok_q <= 32'(synapse) < 32'(stdp_pkg::SYNAPSES);
      time_q   <= time_req;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = word_next;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (state == ST_SCALE && advance && syn_ok_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_q <= mem[stdp_pkg::SYN_AW'(synapse)];
    end
  end

  assign elapsed = time_q - mem_q.last;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      arg_q <= stdp_pkg::ARG_W'(elapsed) * stdp_pkg::ARG_W'(inv_tau);
    end
    if (state == ST_LOOKUP) begin
      rom_hit_q <= (arg_q >> stdp_pkg::ROM_SHIFT) <
                   stdp_pkg::ARG_W'(stdp_pkg::EXP_TABLE_ENTRIES);
    end
  end

  stdp_exp_rom u_rom (
    .clk    (clk),
    .addr   (arg_q[stdp_pkg::ROM_SHIFT +: stdp_pkg::ROM_AW]),
    .factor (rom_data)
  );

  assign factor    = rom_hit_q ? rom_data : '0;
  assign pre_prod  = stdp_pkg::PROD_W'(mem_q.pre) * stdp_pkg::PROD_W'(factor)
                     + stdp_pkg::ROUND_HALF;
  assign post_prod = stdp_pkg::PROD_W'(mem_q.post) * stdp_pkg::PROD_W'(factor)
                     + stdp_pkg::ROUND_HALF;
  assign pre_dec   = pre_prod[16 +: stdp_pkg::TRACE_W];
  assign post_dec  = post_prod[16 +: stdp_pkg::TRACE_W];
  assign pre_sum   = {1'b0, mem_q.pre} + stdp_pkg::ONE_Q16;
  assign post_sum  = {1'b0, mem_q.post} + stdp_pkg::ONE_Q16;
  assign pre_bump  = pre_sum[stdp_pkg::TRACE_W] ? stdp_pkg::TRACE_MAX
                                                : pre_sum[stdp_pkg::TRACE_W-1:0];
  assign post_bump = post_sum[stdp_pkg::TRACE_W] ? stdp_pkg::TRACE_MAX
                                                 : post_sum[stdp_pkg::TRACE_W-1:0];

  always_comb begin
    word_next = mem_q;
    case (mode_q)
      stdp_pkg::MODE_DECAY: begin
        word_next.pre  = pre_dec;
        word_next.post = post_dec;
        word_next.last = time_q;
      end
      stdp_pkg::MODE_PRE:  word_next.pre  = pre_bump;
      stdp_pkg::MODE_POST: word_next.post = post_bump;
      default:             word_next = mem_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SCALE && advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCALE && advance) begin
      pre_trace  <= syn_ok_q ? word_next.pre : '0;
      post_trace <= syn_ok_q ? word_next.post : '0;
    end
  end

`include "assert_macros.svh"

  `STDP_ASSERT(a_one_in_flight, clk, rst, accept |=> (in_stall && state == ST_READ))
  `STDP_ASSERT(a_out_from_scale, clk, rst, $rose(out_valid) |-> $past(state == ST_SCALE))
  `STDP_ASSERT(a_decay_shrinks, clk, rst, (state == ST_SCALE && mode_q == stdp_pkg::MODE_DECAY) |-> (pre_dec <= mem_q.pre && post_dec <= mem_q.post))
  `STDP_ASSERT(a_clear_ends, clk, rst, (state == ST_CLEAR && clr_cnt == stdp_pkg::SYN_AW'(stdp_pkg::SYNAPSES - 1)) |=> (state == ST_IDLE))

endmodule

### test/tb_stdp_trace_decay_engine.sv
// ----------------------------------------------------------------------------
// tb_stdp_trace_decay_engine
// Self-checking testbench for the STDP trace decay engine. Directed requests
// cover the decay table edges, spike saturation, wrapping time and the extreme
// inv_tau settings. Random requests with valid and stall gaps on both sides
// follow. Every result is compared with a behavioral prediction of the traces.
// ----------------------------------------------------------------------------
module tb_stdp_trace_decay_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [63:0] DECAY_STEP = 64'd4228380000;
  localparam int POOL_SIZE = 8;

  typedef struct packed {
    logic [stdp_pkg::TRACE_W-1:0] pre;
    logic [stdp_pkg::TRACE_W-1:0] post;
  } trace_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [stdp_pkg::TAU_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = '0;
  logic [9:0] synapse = '0;
  logic [stdp_pkg::TIME_W-1:0] time_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [stdp_pkg::TRACE_W-1:0] pre_trace;
  logic [stdp_pkg::TRACE_W-1:0] post_trace;

  logic [stdp_pkg::FACTOR_W-1:0] decay_table [stdp_pkg::EXP_TABLE_ENTRIES];
  logic [stdp_pkg::TRACE_W-1:0] pre_model [stdp_pkg::SYNAPSES];
  logic [stdp_pkg::TRACE_W-1:0] post_model [stdp_pkg::SYNAPSES];
  logic [stdp_pkg::TIME_W-1:0] last_model [stdp_pkg::SYNAPSES];
  logic [stdp_pkg::TAU_W-1:0] inv_tau_model = stdp_pkg::INV_TAU_RESET;

  trace_pair_t pending_traces [$];
  int mismatch_count = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;
  int stall_left = 0;
  int hold_cycles = 0;
  logic [stdp_pkg::TIME_W-1:0] tick = '0;
  logic [9:0] hot_synapses [POOL_SIZE];

  stdp_trace_decay_engine dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .synapse(synapse),
    .time_req(time_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pre_trace(pre_trace),
    .post_trace(post_trace)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void fill_decay_table();
    logic [63:0] acc;
    logic [63:0] rounded;
    acc = 64'd1 << 32;
    for (int k = 0; k < stdp_pkg::EXP_TABLE_ENTRIES; k++) begin
      rounded = (acc + 64'h8000) >> 16;
      decay_table[k] = rounded[stdp_pkg::FACTOR_W-1:0];
      acc = (acc * DECAY_STEP + 64'h80000000) >> 32;
    end
    for (int s = 0; s < stdp_pkg::SYNAPSES; s++) begin
      pre_model[s] = '0;
      post_model[s] = '0;
      last_model[s] = '0;
    end
  endfunction

  function automatic logic [stdp_pkg::TRACE_W-1:0] scale_trace(
      logic [stdp_pkg::TRACE_W-1:0] tr, logic [stdp_pkg::FACTOR_W-1:0] f);
    logic [63:0] prod;
    prod = 64'(tr) * 64'(f) + 64'h8000;
    return prod[16 +: stdp_pkg::TRACE_W];
  endfunction

  function automatic logic [stdp_pkg::TRACE_W-1:0] bump_saturated(
      logic [stdp_pkg::TRACE_W-1:0] tr);
    logic [stdp_pkg::TRACE_W:0] sum;
    sum = {1'b0, tr} + 25'd65536;
    return (sum > {1'b0, stdp_pkg::TRACE_MAX}) ? stdp_pkg::TRACE_MAX
                                               : sum[stdp_pkg::TRACE_W-1:0];
  endfunction

  function automatic trace_pair_t predict_traces(logic [1:0] m, logic [9:0] s,
                                                 logic [stdp_pkg::TIME_W-1:0] t);
    logic [stdp_pkg::TIME_W-1:0] elapsed;
    logic [stdp_pkg::ARG_W-1:0] arg;
    logic [stdp_pkg::ARG_W-1:0] idx;
    logic [stdp_pkg::FACTOR_W-1:0] f;
    trace_pair_t res;
    case (stdp_pkg::mode_t'(m))
      stdp_pkg::MODE_DECAY: begin
        elapsed = t - last_model[s];
        arg = stdp_pkg::ARG_W'(elapsed) * stdp_pkg::ARG_W'(inv_tau_model);
        idx = arg >> stdp_pkg::ROM_SHIFT;
        f = (idx < stdp_pkg::ARG_W'(stdp_pkg::EXP_TABLE_ENTRIES))
            ? decay_table[idx[stdp_pkg::ROM_AW-1:0]] : '0;
        pre_model[s] = scale_trace(pre_model[s], f);
        post_model[s] = scale_trace(post_model[s], f);
        last_model[s] = t;
      end
      stdp_pkg::MODE_PRE: pre_model[s] = bump_saturated(pre_model[s]);
      stdp_pkg::MODE_POST: post_model[s] = bump_saturated(post_model[s]);
      default: ;
    endcase
    res.pre = pre_model[s];
    res.post = post_model[s];
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [stdp_pkg::TRACE_W-1:0] exp_v,
                               logic [stdp_pkg::TRACE_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch: expected %06h, got %06h", $realtime, what, exp_v,
               act_v);
    end
  endtask

  always @(posedge clk) begin
    trace_pair_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_traces.push_back(predict_traces(mode, synapse, time_req));
      end
      if (out_valid && !out_stall) begin
        if (pending_traces.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result with no request waiting", $realtime);
          end
        end else begin
          want = pending_traces.pop_front();
          if (pre_trace !== want.pre) note_mismatch("pre_trace", want.pre, pre_trace);
          if (post_trace !== want.post) note_mismatch("post_trace", want.post, post_trace);
        end
        stall_left = $urandom_range(0, out_gap_max);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (out_valid && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a back-to-back request keeps it raised.
  task automatic issue_request(logic [1:0] m, logic [9:0] s,
                               logic [stdp_pkg::TIME_W-1:0] t);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode <= m;
    synapse <= s;
    time_req <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_traces.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_inv_tau(logic [stdp_pkg::TAU_W-1:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    inv_tau_model = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_hot_synapses();
    for (int i = 0; i < POOL_SIZE; i++) begin
      hot_synapses[i] = 10'($urandom_range(0, stdp_pkg::SYNAPSES - 1));
    end
  endtask

  task automatic random_request();
    int r;
    logic [9:0] s;
    r = $urandom_range(0, 99);
    s = hot_synapses[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 5) begin
      issue_request(2'($urandom_range(0, 3)),
                    10'($urandom_range(0, stdp_pkg::SYNAPSES - 1)), $urandom);
    end else if (r < 40) begin
      tick = tick + $urandom_range(0, 32'd1 << $urandom_range(0, 21));
      issue_request(stdp_pkg::MODE_DECAY, s, tick);
    end else if (r < 68) begin
      issue_request(stdp_pkg::MODE_PRE, s, $urandom);
    end else if (r < 96) begin
      issue_request(stdp_pkg::MODE_POST, s, $urandom);
    end else begin
      issue_request(MODE_UNUSED, s, $urandom);
    end
  endtask

  task automatic test_directed_basics();
    in_gap_max = 3;
    out_gap_max = 3;
    issue_request(stdp_pkg::MODE_DECAY, 10'd0, 32'd0);
    issue_request(stdp_pkg::MODE_PRE, 10'd1023, 32'hFFFFFFFF);
    issue_request(stdp_pkg::MODE_POST, 10'd1023, 32'd0);
    issue_request(MODE_UNUSED, 10'd1023, 32'hAAAA5555);
    issue_request(stdp_pkg::MODE_DECAY, 10'd1023, 32'd100);
    issue_request(stdp_pkg::MODE_DECAY, 10'd1023, 32'd100);
    issue_request(stdp_pkg::MODE_PRE, 10'd512, 32'h5555AAAA);
    issue_request(stdp_pkg::MODE_DECAY, 10'd512, 32'hFFFFFFFF);
    issue_request(stdp_pkg::MODE_PRE, 10'd512, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd512, 32'd5);
    wait_drain();
  endtask

  task automatic test_inv_tau_extremes();
    write_inv_tau(16'd0);
    issue_request(stdp_pkg::MODE_PRE, 10'd7, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd7, 32'd1000000);
    write_inv_tau(16'd65535);
    issue_request(stdp_pkg::MODE_PRE, 10'd8, 32'd0);
    issue_request(stdp_pkg::MODE_POST, 10'd8, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd8, 32'd16);
    issue_request(stdp_pkg::MODE_PRE, 10'd8, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd8, 32'd33);
    write_inv_tau(16'd1024);
    issue_request(stdp_pkg::MODE_PRE, 10'd9, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd9, 32'd1023);
    issue_request(stdp_pkg::MODE_PRE, 10'd9, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd9, 32'd2047);
    write_inv_tau(16'd1);
    issue_request(stdp_pkg::MODE_POST, 10'd10, 32'd0);
    issue_request(stdp_pkg::MODE_DECAY, 10'd10, 32'h000FFFFF);
    write_inv_tau(stdp_pkg::INV_TAU_RESET);
  endtask

  task automatic test_saturation();
    in_gap_max = 2;
    out_gap_max = 2;
    for (int i = 0; i < 260; i++) begin
      issue_request(stdp_pkg::MODE_PRE, 10'd300, 32'd0);
      issue_request(stdp_pkg::MODE_POST, 10'd300, 32'd0);
    end
    issue_request(stdp_pkg::MODE_DECAY, 10'd300, 32'd20);
    wait_drain();
  endtask

  task automatic test_backpressure();
    in_gap_max = 0;
    out_gap_max = 0;
    pick_hot_synapses();
    @(posedge clk);
    hold_cycles = 300;
    @(negedge clk);
    repeat (40) random_request();
    wait_drain();
  endtask

  task automatic test_random_phase(int n, logic [stdp_pkg::TAU_W-1:0] tau, int in_gap,
                                   int out_gap);
    write_inv_tau(tau);
    in_gap_max = in_gap;
    out_gap_max = out_gap;
    pick_hot_synapses();
    repeat (n) random_request();
    wait_drain();
  endtask

  initial begin
    fill_decay_table();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_inv_tau_extremes();
    test_saturation();
    test_backpressure();
    test_random_phase(70, 16'($urandom_range(1, 65535)), 18, 18);
    tick = $urandom;
    test_random_phase(65, 16'd65535, 0, 0);
    test_random_phase(65, 16'd1, 18, 0);
    test_random_phase(65, 16'($urandom_range(0, 2048)), 0, 18);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_traces.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/stdp_pkg.sv
src/stdp_exp_rom.sv
src/stdp_trace_decay_engine.sv
test/tb_stdp_trace_decay_engine.sv
